### rtl/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
// Holds the opcode enum, the input and result word structs and the FSM states.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DATA_W = 16;
  localparam int CAP_W  = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } deque_op_t;

  typedef struct packed {
    deque_op_t         func;
    logic [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic              is_empty;
    logic              is_full;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
  } out_word_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } deque_state_t;

endpackage

### rtl/bounded_deque.sv
// Bounded double-ended queue: ring buffer in one slot memory, head pointer and count.
// Depends on bdq_pkg for the opcode, word structs and state encoding.
//
//   port group | dir | handshake             | payload
//   in_        | in  | in_valid / in_ready   | bdq_pkg::in_word_t  (func, value)
//   out_       | out | out_valid / out_ready | bdq_pkg::out_word_t (ok, flags, values)
//   cfg_       | in  | cfg_wr_en, no wait    | cfg_wr_data (capacity, 11 bits)
//
// For each word, the accept cycle updates head and count, writes the slot memory
// and issues both slot reads, which are registered; the response state then loads
// the result register once the output register is free or being taken.
// A stalled result holds in the output register; the next word is taken meanwhile.
// Reset clears head, count and the handshake state and sets capacity to CAP_RESET; slots are not cleared.
`timescale 1ns / 1ps

module bounded_deque #(
  parameter int DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bdq_pkg::in_word_t      in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bdq_pkg::out_word_t     out_word,
  input  logic                   cfg_wr_en,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_wr_data
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int CMP_W = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;

  localparam logic [AW-1:0]    LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [SW-1:0]    DEPTH_S   = SW'(DEPTH);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

  // Ring offset: base plus off, wrapped once (off never exceeds DEPTH).
  function automatic logic [AW-1:0] ring_off(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  // Slot store
  logic [bdq_pkg::DATA_W-1:0] slot_mem [DEPTH];

  // Control and config state
  bdq_pkg::deque_state_t state_r, state_nxt;
  logic [AW-1:0]              head_r, head_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [bdq_pkg::CAP_W-1:0]  cap_r;

  // Response-stage registers
  logic                       ok_r;
  logic                       empty_r;
  logic                       full_r;
  logic                       fwd_front_r;
  logic                       fwd_rear_r;
  logic [bdq_pkg::DATA_W-1:0] fwd_data_r;
  logic [bdq_pkg::DATA_W-1:0] rd_front_r;
  logic [bdq_pkg::DATA_W-1:0] rd_rear_r;

  logic                       out_valid_r;
  bdq_pkg::out_word_t         out_word_r;

  logic                       accept;
  logic                       load_out;

  // Operation datapath
  logic [CMP_W-1:0]           cap_eff;
  logic                       full_now;
  logic                       empty_now;
  logic                       ok;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              head_m1;
  logic [AW-1:0]              head_p1;
  logic [AW-1:0]              front_addr;
  logic [AW-1:0]              rear_addr;
  logic [CW-1:0]              rear_off;
  logic                       full_after;

  assign accept = in_valid && in_ready;

  // Saturate capacity at the store depth
  assign cap_eff   = (CMP_W'(cap_r) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(cap_r);
  assign full_now  = CMP_W'(count_r) >= cap_eff;
  assign empty_now = (count_r == '0);
  assign head_m1   = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign head_p1   = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;

  // Next head, count and slot write for the current word
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = head_r;
    ok        = 1'b0;
    unique case (in_word.func)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (!full_now) begin
          head_nxt  = head_m1;
          wr_addr   = head_m1;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          ok        = 1'b1;
        end
      end
      bdq_pkg::OP_PUSH_REAR: begin
        if (!full_now) begin
          wr_addr   = ring_off(head_r, count_r);
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          ok        = 1'b1;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (!empty_now) begin
          head_nxt  = head_p1;
          count_nxt = count_r - 1'b1;
          ok        = 1'b1;
        end
      end
      bdq_pkg::OP_POP_REAR: begin
        if (!empty_now) begin
          count_nxt = count_r - 1'b1;
          ok        = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Read addresses of the new front and rear entries
  assign rear_off   = (count_nxt == '0) ? '0 : count_nxt - 1'b1;
  assign front_addr = head_nxt;
  assign rear_addr  = ring_off(head_nxt, rear_off);
  assign full_after = CMP_W'(count_nxt) >= cap_eff;

  // Slot memory: one write port, two registered read ports (read-before-write)
  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_en) begin
        slot_mem[wr_addr] <= in_word.value;
      end
      rd_front_r <= slot_mem[front_addr];
      rd_rear_r  <= slot_mem[rear_addr];
    end
  end

  // Capture flags and forward the word being written this cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r        <= ok;
      empty_r     <= (count_nxt == '0);
      full_r      <= full_after;
      fwd_front_r <= wr_en && (wr_addr == front_addr);
      fwd_rear_r  <= wr_en && (wr_addr == rear_addr);
      fwd_data_r  <= in_word.value;
    end
  end

  // Pointer, count and capacity registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      cap_r   <= bdq_pkg::CAP_RESET;
    end else begin
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // FSM: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = bdq_pkg::ST_RESP;
        end
      end
      bdq_pkg::ST_RESP: begin
        if (load_out) begin
          state_nxt = bdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  // FSM: outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      bdq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      bdq_pkg::ST_RESP: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register: hold until taken, drop valid once drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r.ok          <= ok_r;
      out_word_r.is_empty    <= empty_r;
      out_word_r.is_full     <= full_r;
      out_word_r.front_value <= empty_r ? '0 : (fwd_front_r ? fwd_data_r : rd_front_r);
      out_word_r.rear_value  <= empty_r ? '0 : (fwd_rear_r ? fwd_data_r : rd_rear_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(count_r) <= CW'(DEPTH))
    else $error("entry count above store depth");

  a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == bdq_pkg::ST_RESP))
    else $error("accepted word did not enter response state");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r) && $stable(head_r))
    else $error("pointer state moved without an accepted word");

  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !ok |=> $stable(count_r) && $stable(head_r))
    else $error("failed operation changed the queue");

  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == bdq_pkg::ST_IDLE))
    else $error("response not presented after load");

endmodule
